@@ rtl/core/rclf_pkg.sv @@
package rclf_pkg;

  localparam int MAX_BOXES_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int PC_W          = $clog2(MAX_RESULTS + 1);
  localparam int Q_DEPTH       = 4;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

  localparam int S_TDATA_W = 136;
  localparam int M_TDATA_W = 72;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_FILL = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_OFFSET_X  = 3'd2,
    CFG_OFFSET_Y  = 3'd3,
    CFG_BOX_COUNT = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_FLUSH
  } bk_state_e;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [4:0]         box_count;
  } cfg_t;

  // load: box edges; fill: moved rectangle corners
  typedef struct packed {
    op_e                op;
    logic [3:0]         slot;
    logic signed [17:0] a;
    logic signed [17:0] b;
    logic signed [17:0] c;
    logic signed [17:0] d;
  } q_entry_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
  } box_t;

  typedef struct packed {
    logic            idle;
    logic            held_valid;
    logic            push;
    logic            push_last;
    logic [PC_W-1:0] piece_cnt;
  } bk_status_t;

endpackage

@@ rtl/core/rclf_front.sv @@
module rclf_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rclf_pkg::cfg_t                       cfg_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [rclf_pkg::S_TDATA_W-1:0]       s_axis_tdata_i,
  input  logic                                 s_axis_tuser_i,
  input  logic                                 q_full_i,
  output logic                                 q_push_o,
  output rclf_pkg::q_entry_t                   q_data_o
);
  import rclf_pkg::*;

  logic [3:0]         box_index;
  logic signed [15:0] box_left, box_top, box_right, box_bottom;
  logic signed [15:0] rect_x, rect_y;
  logic [15:0]        rect_w, rect_h;
  logic signed [17:0] fx1, fy1, fx2, fy2;
  logic               seen_q;

  assign box_index  = s_axis_tdata_i[3:0];
  assign box_left   = s_axis_tdata_i[19:4];
  assign box_top    = s_axis_tdata_i[35:20];
  assign box_right  = s_axis_tdata_i[51:36];
  assign box_bottom = s_axis_tdata_i[67:52];
  assign rect_x     = s_axis_tdata_i[83:68];
  assign rect_y     = s_axis_tdata_i[99:84];
  assign rect_w     = s_axis_tdata_i[115:100];
  assign rect_h     = s_axis_tdata_i[131:116];

  assign s_axis_tready_o = !q_full_i && seen_q;
  assign q_push_o        = s_axis_tvalid_i && s_axis_tready_o;

  // hold off the input out of reset until seen_q is set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= 1'b1;
    end
  end

  // rectangle moved by the drawable origin, far corner exclusive
  assign fx1 = $signed({{2{rect_x[15]}}, rect_x}) + $signed({{2{cfg_i.origin_x[15]}}, cfg_i.origin_x});
  assign fy1 = $signed({{2{rect_y[15]}}, rect_y}) + $signed({{2{cfg_i.origin_y[15]}}, cfg_i.origin_y});
  assign fx2 = fx1 + $signed({2'b00, rect_w});
  assign fy2 = fy1 + $signed({2'b00, rect_h});

  always_comb begin
    q_data_o.op   = op_e'(s_axis_tuser_i);
    q_data_o.slot = box_index;
    unique case (op_e'(s_axis_tuser_i))
      OP_LOAD: begin
        q_data_o.a = {{2{box_left[15]}}, box_left};
        q_data_o.b = {{2{box_top[15]}}, box_top};
        q_data_o.c = {{2{box_right[15]}}, box_right};
        q_data_o.d = {{2{box_bottom[15]}}, box_bottom};
      end
      OP_FILL: begin
        q_data_o.a = fx1;
        q_data_o.b = fy1;
        q_data_o.c = fx2;
        q_data_o.d = fy2;
      end
      default: begin
        q_data_o.a = fx1;
        q_data_o.b = fy1;
        q_data_o.c = fx2;
        q_data_o.d = fy2;
      end
    endcase
  end

endmodule

@@ rtl/core/rclf_queue.sv @@
module rclf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rclf_pkg::q_entry_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output rclf_pkg::q_entry_t pop_data_o
);
  import rclf_pkg::*;

  q_entry_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q;

  assign full_o     = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/core/rclf_back.sv @@
module rclf_back #(
  parameter int MAX_BOXES = rclf_pkg::MAX_BOXES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rclf_pkg::cfg_t                 cfg_i,
  input  logic                           q_valid_i,
  input  rclf_pkg::q_entry_t             q_data_i,
  output logic                           q_pop_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [rclf_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tlast_o,
  output rclf_pkg::bk_status_t           status_o
);
  import rclf_pkg::*;

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  bk_state_e          state_q, state_d;
  box_t               mem_q [MAX_BOXES];
  box_t               rdata_q;
  logic [CNT_W-1:0]   ia_q, ia_d, cnt;
  logic               b_valid_q, b_valid_d;
  logic signed [17:0] fx1_q, fy1_q, fx2_q, fy2_q;
  logic               held_valid_q;
  logic signed [17:0] held_x_q, held_y_q;
  logic [15:0]        held_w_q, held_h_q;
  logic [PC_W-1:0]    pc_q;
  logic               out_valid_q, out_last_q;
  logic [16:0]        out_x_q, out_y_q;
  logic [15:0]        out_w_q, out_h_q;

  logic signed [17:0] bl, bt, br, bb, ix1, iy1, ix2, iy2, iw, ih, ox, oy;
  logic               issue_ok, nonempty, hit, out_free, consume, adv;
  logic               mem_we, start, rd_en, take, push, push_last, held_clr;

  assign cnt = (32'(cfg_i.box_count) > MAX_BOXES) ? CNT_W'(MAX_BOXES)
                                                  : CNT_W'(cfg_i.box_count);
  assign issue_ok = (ia_q < cnt);

  // intersection of the moved rectangle with the box just read
  assign bl  = {{2{rdata_q.left[15]}}, rdata_q.left};
  assign bt  = {{2{rdata_q.top[15]}}, rdata_q.top};
  assign br  = {{2{rdata_q.right[15]}}, rdata_q.right};
  assign bb  = {{2{rdata_q.bottom[15]}}, rdata_q.bottom};
  assign ix1 = (fx1_q > bl) ? fx1_q : bl;
  assign iy1 = (fy1_q > bt) ? fy1_q : bt;
  assign ix2 = (fx2_q < br) ? fx2_q : br;
  assign iy2 = (fy2_q < bb) ? fy2_q : bb;
  assign iw  = ix2 - ix1;
  assign ih  = iy2 - iy1;
  assign nonempty = (ix1 < ix2) && (iy1 < iy2);
  assign hit      = b_valid_q && nonempty;
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    start     = 1'b0;
    rd_en     = 1'b0;
    take      = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    held_clr  = 1'b0;
    ia_d      = ia_q;
    b_valid_d = b_valid_q;
    consume   = 1'b0;
    adv       = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_data_i.op == OP_FILL) begin
            start     = 1'b1;
            ia_d      = '0;
            b_valid_d = 1'b0;
            state_d   = BK_WALK;
          end else begin
            mem_we = (32'(q_data_i.slot) < MAX_BOXES);
          end
        end
      end
      BK_WALK: begin
        // a hit waits only when the held piece cannot move out
        consume = b_valid_q && (!hit || !held_valid_q || out_free);
        adv     = !b_valid_q || consume;
        if (adv) begin
          if (issue_ok) begin
            rd_en     = 1'b1;
            ia_d      = CNT_W'(ia_q + 1'b1);
            b_valid_d = 1'b1;
          end else begin
            b_valid_d = 1'b0;
          end
        end
        if (consume && hit) begin
          take = 1'b1;
          push = held_valid_q;
          if (pc_q == PC_W'(MAX_RESULTS - 1)) begin
            b_valid_d = 1'b0;
            state_d   = BK_FLUSH;
          end
        end
        if (!b_valid_q && !issue_ok) begin
          state_d = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (!held_valid_q) begin
          state_d = BK_IDLE;
        end else if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          held_clr  = 1'b1;
          state_d   = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      ia_q         <= '0;
      b_valid_q    <= 1'b0;
      held_valid_q <= 1'b0;
      pc_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      ia_q      <= ia_d;
      b_valid_q <= b_valid_d;
      if (start) begin
        pc_q         <= '0;
        held_valid_q <= 1'b0;
      end else if (take) begin
        pc_q         <= pc_q + 1'b1;
        held_valid_q <= 1'b1;
      end else if (held_clr) begin
        held_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // clip box table, read one entry a cycle during the walk while no hit waits on the output
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[IDX_W'(q_data_i.slot)] <= '{left:   q_data_i.a[15:0],
                                        top:    q_data_i.b[15:0],
                                        right:  q_data_i.c[15:0],
                                        bottom: q_data_i.d[15:0]};
    end
    if (rd_en) begin
      rdata_q <= mem_q[ia_q[IDX_W-1:0]];
    end
  end

  assign ox = held_x_q + $signed({{2{cfg_i.offset_x[15]}}, cfg_i.offset_x});
  assign oy = held_y_q + $signed({{2{cfg_i.offset_y[15]}}, cfg_i.offset_y});

  always_ff @(posedge clk_i) begin
    if (start) begin
      fx1_q <= q_data_i.a;
      fy1_q <= q_data_i.b;
      fx2_q <= q_data_i.c;
      fy2_q <= q_data_i.d;
    end
    if (take) begin
      held_x_q <= ix1;
      held_y_q <= iy1;
      held_w_q <= iw[15:0];
      held_h_q <= ih[15:0];
    end
    if (push) begin
      out_x_q    <= ox[16:0];
      out_y_q    <= oy[16:0];
      out_w_q    <= held_w_q;
      out_h_q    <= held_h_q;
      out_last_q <= push_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {6'b0, out_h_q, out_w_q, out_y_q, out_x_q};

  assign status_o.idle       = (state_q == BK_IDLE);
  assign status_o.held_valid = held_valid_q;
  assign status_o.push       = push;
  assign status_o.push_last  = push_last;
  assign status_o.piece_cnt  = pc_q;

endmodule

@@ rtl/core/rect_clip_list_fill.sv @@
// Clips fill rectangles against a table of up to MAX_BOXES clip boxes. A load item
// (tuser 0) writes one box into the table; a fill item (tuser 1) is moved by the
// drawable origin and then walked against the first box_count boxes (at most MAX_BOXES),
// one box a cycle through the single read port of the box table while no hit waits on
// a stalled output. Each non-empty piece comes out as one result; the final piece of a
// rectangle has tlast set, and at most 16 pieces come from one rectangle. A four-entry
// queue between the input side and the walker lets new items be taken while a walk is
// running. Table slots that were never loaded must not be walked. The user must write
// configuration only while the block is idle; the block itself does not enforce it.
module rect_clip_list_fill #(
  parameter int MAX_BOXES = rclf_pkg::MAX_BOXES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rclf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rclf_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // box_index[3:0], box_left[19:4], box_top[35:20], box_right[51:36],
  // box_bottom[67:52], rect_x[83:68], rect_y[99:84], rect_width[115:100],
  // rect_height[131:116], zero pad
  input  logic [rclf_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // opcode
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // fill_x[16:0], fill_y[33:17], fill_width[49:34], fill_height[65:50], zero pad
  output logic [rclf_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);
  import rclf_pkg::*;

  cfg_t       cfg_q;
  q_entry_t   push_data, pop_data;
  logic       q_push, q_pop, q_full, q_valid;
  bk_status_t bk_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_X:  cfg_q.origin_x  <= cfg_data_i;
        CFG_ORIGIN_Y:  cfg_q.origin_y  <= cfg_data_i;
        CFG_OFFSET_X:  cfg_q.offset_x  <= cfg_data_i;
        CFG_OFFSET_Y:  cfg_q.offset_y  <= cfg_data_i;
        CFG_BOX_COUNT: cfg_q.box_count <= cfg_data_i[4:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  rclf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (push_data)
  );

  rclf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  rclf_back #(
    .MAX_BOXES (MAX_BOXES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_data_i        (pop_data),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .status_o        (bk_status)
  );

  // walker back at rest never keeps a piece behind
  a_idle_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.idle |-> !bk_status.held_valid)
    else $error("held piece left over after walk");

  a_piece_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.piece_cnt <= PC_W'(MAX_RESULTS))
    else $error("too many pieces for one rectangle");

  // a piece sent without tlast always has a successor waiting
  a_not_last_has_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_status.push && !bk_status.push_last) |=> bk_status.held_valid)
    else $error("piece sent without tlast but none follows");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_valid && bk_status.idle))
    else $error("queue popped while walker busy or queue empty");

endmodule

@@ sim/tb_rect_clip_list_fill.sv @@
`timescale 1ns / 1ps

module tb_rect_clip_list_fill;
  import rclf_pkg::*;

  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic        last;
  } piece_t;

  class fill_piece_board;
    int          org_x = 0;
    int          org_y = 0;
    int          off_x = 0;
    int          off_y = 0;
    int unsigned boxes_in_use = 0;
    box_t        clip_boxes [MAX_BOXES_DEF];
    piece_t      pieces_due [$];
    int          errors = 0;

    function void set_reg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_ORIGIN_X: org_x = $signed(val);
        CFG_ORIGIN_Y: org_y = $signed(val);
        CFG_OFFSET_X: off_x = $signed(val);
        CFG_OFFSET_Y: off_y = $signed(val);
        CFG_BOX_COUNT: boxes_in_use = val[4:0];
        default: ;
      endcase
    endfunction

    // loads update the table, fills walk it and queue the pieces they produce
    function void note_input(op_e op, logic [S_TDATA_W-1:0] d);
      int     fx1, fy1, fx2, fy2;
      int     x1, y1, x2, y2;
      int     bl, bt, br, bb;
      int     walk_len, made, tmp;
      piece_t held;
      bit     have_held;
      if (op == OP_LOAD) begin
        clip_boxes[d[3:0]] = {d[19:4], d[35:20], d[51:36], d[67:52]};
        return;
      end
      fx1 = $signed(d[83:68]) + org_x;
      fy1 = $signed(d[99:84]) + org_y;
      fx2 = fx1 + $signed({16'd0, d[115:100]});
      fy2 = fy1 + $signed({16'd0, d[131:116]});
      walk_len = (boxes_in_use > MAX_BOXES_DEF) ? MAX_BOXES_DEF : boxes_in_use;
      made = 0;
      have_held = 1'b0;
      held = '0;
      for (int i = 0; i < walk_len; i++) begin
        bl = clip_boxes[i].left;
        bt = clip_boxes[i].top;
        br = clip_boxes[i].right;
        bb = clip_boxes[i].bottom;
        x1 = (fx1 > bl) ? fx1 : bl;
        y1 = (fy1 > bt) ? fy1 : bt;
        x2 = (fx2 < br) ? fx2 : br;
        y2 = (fy2 < bb) ? fy2 : bb;
        if (x1 >= x2 || y1 >= y2) continue;
        if (have_held) begin
          pieces_due.push_back(held);
          made++;
        end
        tmp = x1 + off_x;
        held.x = tmp[16:0];
        tmp = y1 + off_y;
        held.y = tmp[16:0];
        tmp = x2 - x1;
        held.w = tmp[15:0];
        tmp = y2 - y1;
        held.h = tmp[15:0];
        held.last = 1'b0;
        have_held = 1'b1;
        if (made + 1 >= MAX_RESULTS) break;
      end
      if (have_held) begin
        held.last = 1'b1;
        pieces_due.push_back(held);
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] d, logic lst);
      piece_t got, want;
      got = '{x: d[16:0], y: d[33:17], w: d[49:34], h: d[65:50], last: lst};
      if (pieces_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected piece x=%0d y=%0d w=%0d h=%0d last=%0b", $signed(got.x),
                   $signed(got.y), got.w, got.h, got.last);
        return;
      end
      want = pieces_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("want %0d,%0d %0dx%0d last %0b, got %0d,%0d %0dx%0d last %0b",
                   $signed(want.x), $signed(want.y), want.w, want.h, want.last,
                   $signed(got.x), $signed(got.y), got.w, got.h, got.last);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic                 s_axis_tuser_i = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tlast_o;

  fill_piece_board board;
  bit              idling = 1'b0;
  bit              hold_off_req = 1'b0;
  int              stall_left = 0;

  rect_clip_list_fill DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      stall_left = 300;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 18);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      board.check_result(m_axis_tdata_o, m_axis_tlast_o);
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    board.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic send_item(op_e op, logic [S_TDATA_W-1:0] data);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_input(op, data);
    @(negedge clk_i);
  endtask

  // rectangle fields of a load carry junk
  task automatic send_load(logic [3:0] idx, logic [15:0] l, t, r, b);
    send_item(OP_LOAD, {4'd0, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), b, r, t, l, idx});
  endtask

  // box fields of a fill carry junk
  task automatic send_fill(logic [15:0] x, y, w, h);
    send_item(OP_FILL, {4'd0, h, w, y, x, 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 4'($urandom)});
  endtask

  // lets the walker finish fills that give no piece before the next register write
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (board.pieces_due.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_coord();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 500) - 250);
  endfunction

  function automatic logic [15:0] pick_reg();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 120) - 60);
    endcase
  endfunction

  initial begin
    logic [15:0] l, t, r, b, w, h;
    int          n;
    board = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_reg(CFG_ORIGIN_X, 16'd0);
    write_reg(CFG_ORIGIN_Y, 16'd0);
    write_reg(CFG_OFFSET_X, 16'd0);
    write_reg(CFG_OFFSET_Y, 16'd0);
    write_reg(CFG_BOX_COUNT, 16'd0);
    cfg_we_i <= 1'b0;
    // no boxes in use: nothing comes out
    send_fill(16'h0000, 16'h0000, 16'd10, 16'd10);
    // every slot is loaded before any walk can reach it
    send_load(4'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_load(4'd1, 16'd32000, 16'd32000, 16'h7fff, 16'h7fff);
    send_load(4'd2, 16'h8000, 16'h8000, -16'sd32000, -16'sd32000);
    for (int i = 3; i < 16; i++)
      send_load(4'(i), 16'(-100 + (i - 3) * 20), 16'(-60 + i), 16'(-85 + (i - 3) * 20),
                16'd60);
    settle();

    write_reg(CFG_BOX_COUNT, 16'd16);
    cfg_we_i <= 1'b0;
    // full-range rectangle meets all sixteen boxes
    send_fill(16'h8000, 16'h8000, 16'hffff, 16'hffff);
    send_fill(16'd5, 16'd5, 16'd0, 16'd7);
    send_fill(16'hfff0, 16'd0, 16'd40, 16'd0);
    settle();

    write_reg(CFG_ORIGIN_X, 16'h7fff);
    write_reg(CFG_ORIGIN_Y, 16'h8000);
    write_reg(CFG_OFFSET_X, 16'h7fff);
    write_reg(CFG_OFFSET_Y, 16'h8000);
    cfg_we_i <= 1'b0;
    send_fill(16'h8000, 16'h7fff, 16'hffff, 16'hffff);
    send_fill(16'h7fff, 16'h7fff, 16'hffff, 16'hffff);
    send_fill(16'h8010, 16'h7fe0, 16'd100, 16'd100);
    settle();

    write_reg(CFG_ORIGIN_X, 16'h8000);
    write_reg(CFG_ORIGIN_Y, 16'h7fff);
    write_reg(CFG_OFFSET_X, 16'h8000);
    write_reg(CFG_OFFSET_Y, 16'h7fff);
    write_reg(CFG_BOX_COUNT, 16'd1);
    cfg_we_i <= 1'b0;
    send_fill(16'h7fff, 16'h8000, 16'hffff, 16'hffff);
    send_fill(16'h0000, 16'h0000, 16'd1, 16'd1);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      idling = (ph < 8);
      if (ph == 0 || $urandom_range(0, 1)) write_reg(CFG_ORIGIN_X, pick_reg());
      if (ph == 0 || $urandom_range(0, 1)) write_reg(CFG_ORIGIN_Y, pick_reg());
      if (ph == 0 || $urandom_range(0, 1)) write_reg(CFG_OFFSET_X, pick_reg());
      if (ph == 0 || $urandom_range(0, 1)) write_reg(CFG_OFFSET_Y, pick_reg());
      if (ph == 5) n = 31;
      else if (ph == 3 || $urandom_range(0, 3) == 0) n = 16;
      else n = $urandom_range(0, 16);
      write_reg(CFG_BOX_COUNT, 16'(n));
      cfg_we_i <= 1'b0;
      if (ph == 3) begin
        // full-range first box, so nearly every fill gives pieces during the hold-off
        send_load(4'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        // long output hold-off while items keep coming, so the input backs up
        @(posedge clk_i);
        hold_off_req = 1'b1;
        @(negedge clk_i);
      end
      for (int k = 0; k < 25; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          l = pick_coord();
          t = pick_coord();
          if ($urandom_range(0, 7) == 0) begin
            r = 16'($urandom);
            b = 16'($urandom);
          end else begin
            r = l + 16'($urandom_range(1, 160));
            b = t + 16'($urandom_range(1, 160));
          end
          send_load(4'($urandom), l, t, r, b);
        end else begin
          w = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
          h = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
          send_fill(pick_coord(), pick_coord(), w, h);
        end
      end
      settle();
    end

    if (board.pieces_due.size() != 0) board.errors++;
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
